[src/fllp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fllp_pkg
// Shared constants and the result group type of the listing line parser.
// ----------------------------------------------------------------------------
package fllp_pkg;

	localparam int SIZE_BITS   = 64;
	localparam int MAX_RES     = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0]              n;
		logic [MAX_RES-1:0][7:0] bytes;
		logic                    has_verdict;
		logic                    ok;
		logic                    dir;
		logic [63:0]             size;
	} grp_t;

endpackage
`default_nettype wire

[src/ftp_listing_line_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftp_listing_line_parser_top
// Parses MLSD or LIST listing lines into name bytes and an entry verdict.
// ----------------------------------------------------------------------------
// The block takes one line byte or end-of-line item per cycle; the parser
// updates its matchers and decimal accumulator in the cycle of the transfer
// and queues the results that the item causes as one group in a four-entry
// queue. The output register hands out one result per cycle while out_stall
// is low; input stalls only when the queue is full. Write the format register
// only while the block is idle.
module ftp_listing_line_parser_top import fllp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  char_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             out_kind,
	output logic [7:0]       name_byte,
	output logic             entry_ok,
	output logic             is_directory,
	output logic [63:0]      entry_size,
	output logic             last
);

	grp_t wr_grp, rd_grp;
	logic push, pop, full, empty, accept;

	fllp_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .action(action), .char_byte(char_byte),
		.q_full(full), .accept(accept), .push(push), .grp(wr_grp)
	);

	fllp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_grp(wr_grp),
		.pop(pop), .rd_grp(rd_grp), .full(full), .empty(empty)
	);

	fllp_back u_back (
		.clk(clk), .arst_n(arst_n), .head(rd_grp), .empty(empty), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
		.name_byte(name_byte), .entry_ok(entry_ok), .is_directory(is_directory),
		.entry_size(entry_size), .last(last)
	);

	assign in_stall = full && !(accept && 1'b0);

endmodule
`default_nettype wire

[src/fllp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fllp_front
// Accepts line bytes, runs the MLSD or LIST parser and forms result groups.
// ----------------------------------------------------------------------------
module fllp_front import fllp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	input  wire logic       action,
	input  wire logic [7:0] char_byte,
	input  wire logic       q_full,
	output logic            accept,
	output logic            push,
	output grp_t            grp
);

	typedef enum logic [8:0] {
		PH_START   = 9'b000000001,
		PH_KEY     = 9'b000000010,
		PH_VTYPE   = 9'b000000100,
		PH_VSIZE   = 9'b000001000,
		PH_VSKIP   = 9'b000010000,
		PH_GAP     = 9'b000100000,
		PH_FIELD   = 9'b001000000,
		PH_NAMEGAP = 9'b010000000,
		PH_NAME    = 9'b100000000
	} phase_t;

	typedef enum logic [2:0] {TC_EMPTY, TC_CDIR, TC_PDIR, TC_DIR, TC_OTHER} tc_t;
	typedef enum logic [1:0] {LK_FILE, LK_DIR, LK_LINK} lk_t;

	localparam logic [3:0] KP_ZERO = 4'd0;
	localparam logic [3:0] KP_T    = 4'd1;
	localparam logic [3:0] KP_TYPE = 4'd4;
	localparam logic [3:0] KP_S    = 4'd5;
	localparam logic [3:0] KP_SIZE = 4'd8;
	localparam logic [3:0] VP_C    = 4'd1;
	localparam logic [3:0] VP_CDIR = 4'd4;
	localparam logic [3:0] VP_P    = 4'd5;
	localparam logic [3:0] VP_PDIR = 4'd8;
	localparam logic [3:0] VP_D    = 4'd9;
	localparam logic [3:0] VP_DIR  = 4'd11;
	localparam logic [3:0] KP_NONE = 4'd15;

	localparam logic [SIZE_BITS-1:0] SIZE_CAP = '1;

	typedef struct packed {
		logic [4:0][7:0]         held;
		logic [2:0]              hc;
		logic [1:0]              nl;
		logic [1:0]              ap;
		logic                    trunc;
		logic [MAX_RES-1:0][7:0] ob;
		logic [2:0]              on;
	} nm_t;

	typedef struct packed {
		logic                 ended;
		logic [SIZE_BITS-1:0] acc;
	} sz_t;

	function automatic nm_t emit(nm_t s, logic [7:0] x);
		if (s.on < 3'(MAX_RES)) begin
			s.ob[s.on] = x;
			s.on = s.on + 3'd1;
		end
		return s;
	endfunction

	function automatic nm_t confirm(nm_t s, logic [7:0] x);
		if (s.hc == {1'b0, s.nl} && s.nl < 2'd2 && x == ".") begin
			s.held[s.hc[1:0]] = x;
			s.hc = s.hc + 3'd1;
			s.nl = s.nl + 2'd1;
		end else begin
			for (int i = 0; i < 5; i++) begin
				if (3'(i) < s.hc) s = emit(s, s.held[i]);
			end
			s.hc = 3'd0;
			s = emit(s, x);
			if (s.nl < 2'd3) s.nl = s.nl + 2'd1;
		end
		return s;
	endfunction

	function automatic nm_t release_pend(nm_t s);
		logic [2:0]      p;
		logic [2:0]      d;
		logic [2:0][7:0] pend;
		p = {1'b0, s.ap};
		d = (s.hc >= p) ? s.hc - p : 3'd0;
		if (d > 3'd2) d = 3'd2;
		for (int j = 0; j < 3; j++) pend[j] = s.held[d + 3'(j)];
		s.hc = d;
		s.ap = 2'd0;
		for (int j = 0; j < 3; j++) begin
			if (3'(j) < p) s = confirm(s, pend[j]);
		end
		return s;
	endfunction

	function automatic logic [7:0] arrow_char(logic [1:0] ap);
		logic [7:0] r;
		case (ap)
			2'd1:    r = "-";
			2'd2:    r = ">";
			default: r = " ";
		endcase
		return r;
	endfunction

	function automatic nm_t name_char(nm_t s, logic link, logic [7:0] c);
		if (!s.trunc) begin
			if (!link) begin
				s = confirm(s, c);
			end else if (c == arrow_char(s.ap)) begin
				if (s.ap == 2'd3) begin
					s.hc = (s.hc >= 3'd3) ? s.hc - 3'd3 : 3'd0;
					s.ap = 2'd0;
					s.trunc = 1'b1;
				end else if (s.hc < 3'd5) begin
					s.held[s.hc] = c;
					s.hc = s.hc + 3'd1;
					s.ap = s.ap + 2'd1;
				end
			end else begin
				s = release_pend(s);
				if (c == " " && s.hc < 3'd5) begin
					s.held[s.hc] = c;
					s.hc = s.hc + 3'd1;
					s.ap = 2'd1;
				end else begin
					s = confirm(s, c);
				end
			end
		end
		return s;
	endfunction

	function automatic sz_t size_digit(sz_t z, logic [7:0] c);
		logic [SIZE_BITS+3:0] t;
		if (!z.ended) begin
			if (c >= "0" && c <= "9") begin
				t = ({4'd0, z.acc} << 3) + ({4'd0, z.acc} << 1)
					+ (SIZE_BITS+4)'(c - "0");
				z.acc = (t > {4'd0, SIZE_CAP}) ? SIZE_CAP : t[SIZE_BITS-1:0];
			end else begin
				z.ended = 1'b1;
			end
		end
		return z;
	endfunction

	function automatic logic [3:0] key_next(logic [3:0] k, logic [7:0] c);
		logic [3:0] r;
		r = KP_NONE;
		case (k)
			4'd0: r = (c == "t") ? KP_T : ((c == "s") ? KP_S : KP_NONE);
			4'd1: if (c == "y") r = k + 4'd1;
			4'd2: if (c == "p") r = k + 4'd1;
			4'd3: if (c == "e") r = k + 4'd1;
			4'd5: if (c == "i") r = k + 4'd1;
			4'd6: if (c == "z") r = k + 4'd1;
			4'd7: if (c == "e") r = k + 4'd1;
			default: r = KP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] val_next(logic [3:0] k, logic [7:0] c);
		logic [3:0] r;
		r = KP_NONE;
		case (k)
			4'd0: r = (c == "c") ? VP_C : ((c == "p") ? VP_P :
				((c == "d") ? VP_D : KP_NONE));
			4'd1, 4'd5: if (c == "d") r = k + 4'd1;
			4'd2, 4'd6, 4'd9: if (c == "i") r = k + 4'd1;
			4'd3, 4'd7, 4'd10: if (c == "r") r = k + 4'd1;
			default: r = KP_NONE;
		endcase
		return r;
	endfunction

	function automatic tc_t val_class(logic [3:0] k);
		tc_t r;
		case (k)
			KP_ZERO: r = TC_EMPTY;
			VP_CDIR: r = TC_CDIR;
			VP_PDIR: r = TC_PDIR;
			VP_DIR:  r = TC_DIR;
			default: r = TC_OTHER;
		endcase
		return r;
	endfunction

	logic                 fmt_q;
	phase_t               ph_q, ph_d;
	logic [3:0]           fi_q, fi_d;
	logic [3:0]           kp_q, kp_d;
	tc_t                  tc_q, tc_d;
	lk_t                  lk_q, lk_d;
	sz_t                  sz_q, sz_d;
	logic [4:0][7:0]      held_q;
	logic [2:0]           hc_q;
	logic [1:0]           nl_q, ap_q;
	logic                 trunc_q;
	nm_t                  s;
	logic [7:0]           c, lc;
	logic                 v_ok, v_dir;

	assign accept = in_valid && !q_full;
	assign c      = char_byte;
	assign lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

	always_comb begin
		ph_d = ph_q;
		fi_d = fi_q;
		kp_d = kp_q;
		tc_d = tc_q;
		lk_d = lk_q;
		sz_d = sz_q;
		s.held  = held_q;
		s.hc    = hc_q;
		s.nl    = nl_q;
		s.ap    = ap_q;
		s.trunc = trunc_q;
		s.ob    = '0;
		s.on    = 3'd0;
		v_ok    = 1'b0;
		v_dir   = 1'b0;
		grp     = '0;
		if (action) begin
			if (ph_q == PH_NAME) begin
				s = release_pend(s);
				v_ok = (s.nl != 2'd0) && (s.hc == 3'd0);
				if (!fmt_q) begin
					if (tc_q == TC_EMPTY || tc_q == TC_CDIR || tc_q == TC_PDIR) v_ok = 1'b0;
					v_dir = (tc_q == TC_DIR);
				end else begin
					v_dir = (lk_q == LK_DIR);
				end
			end
			if (!v_ok) v_dir = 1'b0;
			grp.ok  = v_ok;
			grp.dir = v_dir;
			grp.size = (v_ok && !v_dir) ? 64'(sz_q.acc) : 64'd0;
			ph_d = PH_START;
			fi_d = 4'd0;
			kp_d = KP_ZERO;
			tc_d = TC_EMPTY;
			lk_d = LK_FILE;
			sz_d = '0;
		end else if (!fmt_q) begin
			if (ph_d == PH_START) begin
				ph_d = PH_KEY;
				kp_d = KP_ZERO;
			end
			if (ph_d == PH_NAME) begin
				s = name_char(s, 1'b0, c);
			end else if (c == " " || c == ";") begin
				if (ph_d == PH_VTYPE) tc_d = val_class(kp_d);
				kp_d = KP_ZERO;
				ph_d = (c == " ") ? PH_NAME : PH_KEY;
			end else begin
				case (ph_d)
					PH_KEY: begin
						if (c == "=") begin
							if (kp_d == KP_TYPE) begin
								ph_d = PH_VTYPE;
							end else if (kp_d == KP_SIZE) begin
								ph_d = PH_VSIZE;
								sz_d = '0;
							end else begin
								ph_d = PH_VSKIP;
							end
							kp_d = KP_ZERO;
						end else begin
							kp_d = key_next(kp_d, lc);
						end
					end
					PH_VTYPE: kp_d = val_next(kp_d, lc);
					PH_VSIZE: sz_d = size_digit(sz_d, c);
					default: ;
				endcase
			end
		end else begin
			if (ph_d == PH_START) begin
				lk_d = (c == "d") ? LK_DIR : ((c == "l") ? LK_LINK : LK_FILE);
				fi_d = 4'd0;
				ph_d = PH_GAP;
			end
			case (ph_d)
				PH_GAP: begin
					if (c != " ") begin
						ph_d = PH_FIELD;
						if (fi_d == 4'd4) sz_d = size_digit(sz_d, c);
					end
				end
				PH_FIELD: begin
					if (c == " ") begin
						fi_d = fi_d + 4'd1;
						ph_d = (fi_d >= 4'd8) ? PH_NAMEGAP : PH_GAP;
					end else if (fi_d == 4'd4) begin
						sz_d = size_digit(sz_d, c);
					end
				end
				PH_NAMEGAP: begin
					if (c != " ") begin
						ph_d = PH_NAME;
						s = name_char(s, lk_d == LK_LINK, c);
					end
				end
				PH_NAME: s = name_char(s, lk_d == LK_LINK, c);
				default: ;
			endcase
		end
		grp.bytes = s.ob;
		grp.n     = s.on;
		if (action && s.on < 3'(MAX_RES)) begin
			grp.has_verdict = 1'b1;
			grp.n = s.on + 3'd1;
		end
	end

	assign push = accept && (grp.n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= 1'b0;
			ph_q    <= PH_START;
			fi_q    <= 4'd0;
			kp_q    <= KP_ZERO;
			tc_q    <= TC_EMPTY;
			lk_q    <= LK_FILE;
			sz_q    <= '0;
			hc_q    <= 3'd0;
			nl_q    <= 2'd0;
			ap_q    <= 2'd0;
			trunc_q <= 1'b0;
		end else if (cfg_we) begin
			fmt_q   <= cfg_wdata;
			ph_q    <= PH_START;
			fi_q    <= 4'd0;
			kp_q    <= KP_ZERO;
			tc_q    <= TC_EMPTY;
			lk_q    <= LK_FILE;
			sz_q    <= '0;
			hc_q    <= 3'd0;
			nl_q    <= 2'd0;
			ap_q    <= 2'd0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			ph_q    <= ph_d;
			fi_q    <= fi_d;
			kp_q    <= kp_d;
			tc_q    <= tc_d;
			lk_q    <= lk_d;
			sz_q    <= sz_d;
			hc_q    <= action ? 3'd0 : s.hc;
			nl_q    <= action ? 2'd0 : s.nl;
			ap_q    <= action ? 2'd0 : s.ap;
			trunc_q <= action ? 1'b0 : s.trunc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_we) held_q <= s.held;
	end

endmodule
`default_nettype wire

[src/fllp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fllp_queue
// Short queue of result groups between the parser and the output stage.
// ----------------------------------------------------------------------------
module fllp_queue import fllp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  grp_t      wr_grp,
	input  wire logic pop,
	output grp_t      rd_grp,
	output logic      full,
	output logic      empty
);

	grp_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_grp = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

[src/fllp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fllp_back
// Unpacks result groups into single results held in an output register.
// ----------------------------------------------------------------------------
module fllp_back import fllp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  grp_t             head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             out_kind,
	output logic [7:0]       name_byte,
	output logic             entry_ok,
	output logic             is_directory,
	output logic [63:0]      entry_size,
	output logic             last
);

	logic [2:0] idx_q;
	logic       ov_q;
	logic       load, at_end, vk;

	assign load   = !empty && (!ov_q || !out_stall);
	assign at_end = (idx_q == head.n - 3'd1);
	assign vk     = head.has_verdict && at_end;
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind     <= vk;
			name_byte    <= vk ? 8'd0 : head.bytes[idx_q];
			entry_ok     <= vk && head.ok;
			is_directory <= vk && head.dir;
			entry_size   <= vk ? head.size : 64'd0;
			last         <= at_end;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

[src/fllp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fllp_checker
// Port-level checks of the result stream of the listing line parser.
// ----------------------------------------------------------------------------
module fllp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        out_kind,
	input wire logic [7:0]  name_byte,
	input wire logic        entry_ok,
	input wire logic        is_directory,
	input wire logic [63:0] entry_size,
	input wire logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(name_byte) && $stable(out_kind))
		else $error("stalled result changed");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> !entry_ok && !is_directory && entry_size == 64'd0)
		else $error("name byte result carries verdict fields");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> last && name_byte == 8'd0)
		else $error("verdict is not the final result");

	a_dir_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (is_directory || !entry_ok) |-> entry_size == 64'd0)
		else $error("size reported for a directory or rejected line");

endmodule

bind ftp_listing_line_parser_top fllp_checker u_fllp_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_kind(out_kind), .name_byte(name_byte), .entry_ok(entry_ok),
	.is_directory(is_directory), .entry_size(entry_size), .last(last)
);
`default_nettype wire
